>>> rtl/core/eva_pkg.sv
// Package for the encoder velocity and acceleration estimator.
// Holds field widths, fixed-point scale constants and the divider request type.
// No dependencies; used by eva_div and encoder_velocity_accel_estimator.
package eva_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int RAW_W      = 16;
  localparam int TIME_W     = 48;
  localparam int ANGLE_Q4_W = 13;
  localparam int VEL_W      = 40;
  localparam int ACC_W      = 48;
  localparam int IN_DATA_W  = RAW_W + TIME_W;
  localparam int OUT_FLD_W  = ANGLE_BITS + ANGLE_Q4_W + VEL_W + ACC_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam int DIFF_W     = ANGLE_BITS + 2;
  localparam int DMAG_W     = ANGLE_BITS + 1;
  localparam int SCALE_W    = 33;
  localparam int VPROD_W    = DMAG_W + SCALE_W;
  localparam int VNUM_W     = 32;
  localparam int VDIFF_W    = VEL_W + 1;
  localparam int USEC_W     = 20;
  localparam int DIV_W      = VDIFF_W + USEC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int DEG_W      = 13;

  localparam logic [SCALE_W-1:0] VEL_SCALE   = 33'd5760000000;
  localparam logic [USEC_W-1:0]  US_PER_S    = 20'd1000000;
  localparam logic [DEG_W-1:0]   DEG_Q4_TURN = 13'd5760;

  localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(1) <<< ANGLE_BITS;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [DIV_W-1:0] ACC_POS_LIM = DIV_W'(ACC_MAX);
  localparam logic [DIV_W-1:0] ACC_NEG_LIM = DIV_W'(1) << (ACC_W - 1);

  localparam logic [DIV_CNT_W-1:0] VEL_ITERS = DIV_CNT_W'(VNUM_W);
  localparam logic [DIV_CNT_W-1:0] ACC_ITERS = DIV_CNT_W'(DIV_W);

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
  } div_req_t;

endpackage

>>> rtl/core/eva_div.sv
// Bit-serial restoring divider shared by the velocity and acceleration steps.
// Depends on eva_pkg for widths and the request struct.
// The dividend is left-aligned; quotient bits shift into the dividend register.
module eva_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  eva_pkg::div_req_t           req_i,
  input  logic [eva_pkg::DIV_W-1:0]   dividend_i,
  input  logic [eva_pkg::TIME_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [eva_pkg::DIV_W-1:0]   quot_o
);

  logic [eva_pkg::DIV_W-1:0]     num_q;
  logic [eva_pkg::TIME_W-1:0]    dvs_q;
  logic [eva_pkg::TIME_W-1:0]    rem_q;
  logic [eva_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;

  logic [eva_pkg::TIME_W:0]      shifted;
  logic [eva_pkg::TIME_W:0]      trial;
  logic                          qbit;

  always_comb begin
    shifted = {rem_q, num_q[eva_pkg::DIV_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    qbit    = !trial[eva_pkg::TIME_W];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[eva_pkg::DIV_W-2:0], qbit};
      rem_q <= qbit ? trial[eva_pkg::TIME_W-1:0] : shifted[eva_pkg::TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - eva_pkg::DIV_CNT_W'(1);
        if (cnt_q == eva_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == eva_pkg::DIV_CNT_W'(1)) |=> done_q)
    else $error("divider missed its done pulse");
`endif

endmodule

>>> rtl/core/encoder_velocity_accel_estimator.sv
// Top level of the encoder velocity and acceleration estimator.
// Depends on eva_pkg and instantiates the shared divider eva_div.
//
// Each input transaction carries a 12-bit angle count, a 48-bit microsecond
// timestamp and a read-ok flag; a transaction with the flag low is taken and
// dropped without starting a computation or changing the previous-sample state.
// A good sample yields one output transaction with the count, the angle in
// degrees (Q.4), the velocity in deg/s (Q.4) and the acceleration in deg/s^2
// (Q.4), both signed and saturating, plus a flag for zero elapsed time. The
// block holds one sample at a time: the single bit-serial divider runs 32 steps
// for the velocity and 61 steps for the acceleration, between the sequencing
// states. With zero elapsed time both divisions are skipped. A finished result
// waits in the output register while the next sample is accepted. Writing the
// configuration register loads the previous timestamp used by the next sample.
module encoder_velocity_accel_estimator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: raw_reading[15:0], time_us[63:16]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [eva_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: read_ok
  input  logic                            s_axis_tuser,
  // tdata: angle_count[11:0], angle_deg_q4[24:12], velocity_q4[64:25],
  // accel_q4[112:65], zero fill above
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [eva_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tuser: div_zero
  output logic                            m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [eva_pkg::TIME_W-1:0]      cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VMUL,
    ST_VDIV,
    ST_ADIFF,
    ST_AMUL,
    ST_ADIV,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [eva_pkg::ANGLE_BITS-1:0]    last_angle_q;
  logic [eva_pkg::TIME_W-1:0]        last_time_q;
  logic signed [eva_pkg::VEL_W-1:0]  last_vel_q;

  logic [eva_pkg::ANGLE_BITS-1:0]    count_q;
  logic [eva_pkg::TIME_W-1:0]        now_q;
  logic [eva_pkg::TIME_W-1:0]        dt_q;
  logic                              dt_zero_q;
  logic signed [eva_pkg::DIFF_W-1:0] d_q;
  logic signed [eva_pkg::VEL_W-1:0]  vel_q;
  logic signed [eva_pkg::ACC_W-1:0]  acc_q;
  logic                              vneg_q;
  logic [eva_pkg::VDIFF_W-1:0]       vmag_q;

  logic                              m_valid_q;
  logic [eva_pkg::OUT_DATA_W-1:0]    m_data_q;
  logic                              m_user_q;

  logic [eva_pkg::ANGLE_BITS-1:0]    count_in;
  logic [eva_pkg::TIME_W-1:0]        time_in;
  logic [eva_pkg::TIME_W-1:0]        dt_in;
  logic signed [eva_pkg::DIFF_W-1:0] diff_raw;
  logic signed [eva_pkg::DIFF_W-1:0] d_in;
  logic signed [eva_pkg::DIFF_W-1:0] d_abs;
  logic [eva_pkg::VPROD_W-1:0]       vprod;
  logic [eva_pkg::DIV_W-1:0]         vnum;
  logic [eva_pkg::DIV_W-1:0]         anum;
  logic signed [eva_pkg::VDIFF_W-1:0] vdiff;
  logic [eva_pkg::DIV_W-1:0]         quot;
  logic [eva_pkg::VNUM_W-1:0]        vq;
  logic signed [eva_pkg::VEL_W-1:0]  vel_div;
  logic signed [eva_pkg::ACC_W-1:0]  acc_div;
  logic [eva_pkg::ANGLE_BITS+eva_pkg::DEG_W-1:0] ang_prod;
  logic [eva_pkg::ANGLE_Q4_W-1:0]    angle_q4;
  logic                              div_done;
  logic                              out_load;
  eva_pkg::div_req_t                 div_req;
  logic [eva_pkg::DIV_W-1:0]         div_num;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    count_in = s_axis_tdata[eva_pkg::ANGLE_BITS-1:0];
    time_in  = s_axis_tdata[eva_pkg::IN_DATA_W-1:eva_pkg::RAW_W];
    dt_in    = time_in - last_time_q;
    diff_raw = $signed({2'b00, count_in}) - $signed({2'b00, last_angle_q});
    if (diff_raw > eva_pkg::HALF_TURN) begin
      d_in = diff_raw - eva_pkg::FULL_TURN;
    end else if (diff_raw < -eva_pkg::HALF_TURN) begin
      d_in = diff_raw + eva_pkg::FULL_TURN;
    end else begin
      d_in = diff_raw;
    end

    d_abs = d_q[eva_pkg::DIFF_W-1] ? -d_q : d_q;
    vprod = eva_pkg::VPROD_W'(d_abs[eva_pkg::DMAG_W-1:0]) * eva_pkg::VPROD_W'(eva_pkg::VEL_SCALE);
    vnum  = {vprod[eva_pkg::ANGLE_BITS +: eva_pkg::VNUM_W],
             {(eva_pkg::DIV_W-eva_pkg::VNUM_W){1'b0}}};
    anum  = eva_pkg::DIV_W'(vmag_q) * eva_pkg::DIV_W'(eva_pkg::US_PER_S);

    vdiff = eva_pkg::VDIFF_W'(vel_q) - eva_pkg::VDIFF_W'(last_vel_q);

    vq      = quot[eva_pkg::VNUM_W-1:0];
    vel_div = d_q[eva_pkg::DIFF_W-1] ? -$signed(eva_pkg::VEL_W'(vq)) : $signed(eva_pkg::VEL_W'(vq));
    if (!vneg_q) begin
      acc_div = (quot > eva_pkg::ACC_POS_LIM) ? eva_pkg::ACC_MAX
                                              : $signed(quot[eva_pkg::ACC_W-1:0]);
    end else begin
      acc_div = (quot > eva_pkg::ACC_NEG_LIM) ? eva_pkg::ACC_MIN
                                              : -$signed(quot[eva_pkg::ACC_W-1:0]);
    end

    ang_prod = {{eva_pkg::DEG_W{1'b0}}, count_q} * {{eva_pkg::ANGLE_BITS{1'b0}}, eva_pkg::DEG_Q4_TURN};
    angle_q4 = ang_prod[eva_pkg::ANGLE_BITS +: eva_pkg::ANGLE_Q4_W];

    div_req.start = ((state_q == ST_VMUL) || (state_q == ST_AMUL)) && !dt_zero_q;
    div_req.iters = (state_q == ST_VMUL) ? eva_pkg::VEL_ITERS : eva_pkg::ACC_ITERS;
    div_num       = (state_q == ST_VMUL) ? vnum : anum;

    out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
  end

  eva_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_num),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      count_q   <= count_in;
      now_q     <= time_in;
      dt_q      <= dt_in;
      dt_zero_q <= (dt_in == '0);
      d_q       <= d_in;
    end
    if (out_load) begin
      m_data_q <= {{(eva_pkg::OUT_DATA_W-eva_pkg::OUT_FLD_W){1'b0}},
                   acc_q, vel_q, angle_q4, count_q};
      m_user_q <= dt_zero_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_angle_q <= '0;
      last_time_q  <= '0;
      last_vel_q   <= '0;
      vel_q        <= '0;
      acc_q        <= '0;
      vneg_q       <= 1'b0;
      vmag_q       <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        last_time_q <= cfg_wdata_i;
      end else if (out_load) begin
        last_time_q <= now_q;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tuser) begin
            state_q <= ST_VMUL;
          end
        end
        ST_VMUL: begin
          if (dt_zero_q) begin
            if (d_q > 0) begin
              vel_q <= eva_pkg::VEL_MAX;
            end else if (d_q < 0) begin
              vel_q <= eva_pkg::VEL_MIN;
            end else begin
              vel_q <= '0;
            end
            state_q <= ST_ADIFF;
          end else begin
            state_q <= ST_VDIV;
          end
        end
        ST_VDIV: begin
          if (div_done) begin
            vel_q   <= vel_div;
            state_q <= ST_ADIFF;
          end
        end
        ST_ADIFF: begin
          vneg_q  <= vdiff[eva_pkg::VDIFF_W-1];
          vmag_q  <= vdiff[eva_pkg::VDIFF_W-1] ? eva_pkg::VDIFF_W'(-vdiff)
                                               : eva_pkg::VDIFF_W'(vdiff);
          state_q <= ST_AMUL;
        end
        ST_AMUL: begin
          if (dt_zero_q) begin
            if (vmag_q == '0) begin
              acc_q <= '0;
            end else if (vneg_q) begin
              acc_q <= eva_pkg::ACC_MIN;
            end else begin
              acc_q <= eva_pkg::ACC_MAX;
            end
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_ADIV;
          end
        end
        ST_ADIV: begin
          if (div_done) begin
            acc_q   <= acc_div;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            last_angle_q <= count_q;
            last_vel_q   <= vel_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  a_zero_dt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q) |->
      (m_data_q[64:25] == eva_pkg::VEL_MAX || m_data_q[64:25] == eva_pkg::VEL_MIN ||
       m_data_q[64:25] == '0))
    else $error("zero elapsed time without saturated velocity");
  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q) |->
      (m_data_q[64:57] == 8'h00 || m_data_q[64:57] == 8'hFF))
    else $error("divided velocity out of its range");
  a_time_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !cfg_we_i) |=> (last_time_q == $past(now_q)))
    else $error("previous time not updated at result load");
  a_vdiv_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VDIV && div_done) |=> (state_q == ST_ADIFF))
    else $error("sequencer missed velocity divide completion");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for encoder_velocity_accel_estimator.
// Depends on eva_pkg and the block; drives both stream ports with random gaps
// and stalls, and compares every output transaction with an in-bench predictor.
module testbench;
  import eva_pkg::*;

  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  SETTLE      = 150;
  localparam int  PHASE_ITEMS = 205;
  localparam longint TURN     = longint'(1) << ANGLE_BITS;
  localparam longint HALF     = TURN / 2;
  localparam longint VEL_NUM  = 64'd5760000000;
  localparam longint USEC     = 64'd1000000;

  typedef struct {
    longint angle_count;
    longint angle_q4;
    longint vel;
    longint acc;
    bit     div_zero;
  } motion_t;

  class motion_scoreboard;
    logic [ANGLE_BITS-1:0] last_angle;
    logic [TIME_W-1:0]     last_time;
    longint                last_vel;
    motion_t               pending_motion[$];
    int                    errors;
    int                    n_checked;
    int                    n_div_zero;
    int                    n_clamped;

    function new();
      last_angle = '0;
      last_time  = '0;
      last_vel   = 0;
      errors     = 0;
      n_checked  = 0;
      n_div_zero = 0;
      n_clamped  = 0;
    endfunction

    function void load_start(logic [TIME_W-1:0] value);
      last_time = value;
    endfunction

    // Quotient truncated toward zero and clamped; a zero divisor clamps by sign.
    function longint div_clamp(longint num, logic [63:0] den, longint lo, longint hi);
      logic [63:0] mag;
      logic [63:0] q;
      if (num == 0) return 0;
      if (den == 0) return (num < 0) ? lo : hi;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      if (num < 0) return (q > 64'(-lo)) ? lo : -longint'(q);
      return (q > 64'(hi)) ? hi : longint'(q);
    endfunction

    function void note_sample(logic [RAW_W-1:0] raw, logic [TIME_W-1:0] t_us, logic ok);
      logic [ANGLE_BITS-1:0] count;
      logic [TIME_W-1:0]     dt;
      longint                d;
      longint                vel_min;
      longint                vel_max;
      longint                acc_min;
      longint                acc_max;
      motion_t               m;
      if (!ok) return;
      vel_min = longint'(VEL_MIN);
      vel_max = longint'(VEL_MAX);
      acc_min = longint'(ACC_MIN);
      acc_max = longint'(ACC_MAX);
      count = raw[ANGLE_BITS-1:0];
      dt = t_us - last_time;
      d = longint'({52'd0, count}) - longint'({52'd0, last_angle});
      if (d > HALF) d -= TURN;
      else if (d < -HALF) d += TURN;
      m.angle_count = longint'({52'd0, count});
      m.angle_q4    = (longint'({52'd0, count}) * 5760) >>> ANGLE_BITS;
      m.vel         = div_clamp(d * VEL_NUM, {4'd0, dt, 12'd0}, vel_min, vel_max);
      m.acc         = div_clamp((m.vel - last_vel) * USEC, {16'd0, dt}, acc_min, acc_max);
      m.div_zero    = (dt == 0);
      if (m.vel == vel_min || m.vel == vel_max || m.acc == acc_min || m.acc == acc_max) begin
        n_clamped++;
      end
      pending_motion.push_back(m);
      last_angle = count;
      last_time  = t_us;
      last_vel   = m.vel;
    endfunction

    function void check_field(string name, longint expected, longint actual);
      if (expected != actual) begin
        $error("%s expected %0d actual %0d", name, expected, actual);
        errors++;
      end
    endfunction

    function void check_motion(logic [OUT_DATA_W-1:0] data, logic dz);
      motion_t m;
      if (pending_motion.size() == 0) begin
        $error("output transaction with no sample pending");
        errors++;
        return;
      end
      m = pending_motion.pop_front();
      check_field("angle_count", m.angle_count, longint'({52'd0, data[11:0]}));
      check_field("angle_deg_q4", m.angle_q4, longint'({51'd0, data[24:12]}));
      check_field("velocity_q4", m.vel, longint'($signed(data[64:25])));
      check_field("accel_q4", m.acc, longint'($signed(data[112:65])));
      check_field("div_zero", longint'(m.div_zero), longint'(dz));
      n_checked++;
      if (m.div_zero) n_div_zero++;
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [TIME_W-1:0]     cfg_wdata_i   = '0;

  motion_scoreboard      sb = new();
  int                    cycles     = 0;
  int                    stall_left = 0;
  int                    cfg_writes = 0;
  bit                    gaps_on    = 1'b1;
  logic [TIME_W-1:0]     gen_time   = '0;
  logic [ANGLE_BITS-1:0] gen_angle  = '0;

  encoder_velocity_accel_estimator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("encoder_velocity_accel_estimator verification failed");
      $finish;
    end
  end

  // The output check runs first because a result never belongs to the sample
  // taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_motion(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_sample(s_axis_tdata[15:0], s_axis_tdata[63:16], s_axis_tuser);
      end
      if (cfg_we_i) sb.load_start(cfg_wdata_i);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_sample(logic [RAW_W-1:0] raw, logic [TIME_W-1:0] t_us, logic ok);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t_us, raw};
    s_axis_tuser  <= ok;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (ok) begin
      gen_time  = t_us;
      gen_angle = raw[ANGLE_BITS-1:0];
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_motion.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_start(logic [TIME_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    gen_time    = value;
    cfg_writes++;
  endtask

  // Mostly plausible motion: small time steps and nearby angles, with some
  // half-turn jumps, random angles, huge or backward time steps and failed reads.
  task automatic random_sample(output bit ok_out);
    logic [RAW_W-1:0]  raw;
    logic [TIME_W-1:0] t_us;
    logic              ok;
    int                sel;
    ok  = ($urandom_range(0, 11) != 0);
    sel = $urandom_range(0, 99);
    if (sel < 6) t_us = gen_time;
    else if (sel < 25) t_us = gen_time + 48'($urandom_range(1, 16));
    else if (sel < 50) t_us = gen_time + 48'($urandom_range(17, 2000));
    else if (sel < 70) t_us = gen_time + 48'($urandom_range(2001, 200000));
    else if (sel < 82) t_us = gen_time + 48'($urandom);
    else if (sel < 90) t_us = gen_time + 48'({$urandom, $urandom});
    else t_us = 48'({$urandom, $urandom});
    raw = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      raw[ANGLE_BITS-1:0] = gen_angle + 12'($urandom_range(0, 400)) - 12'd200;
    end else if (sel < 80) begin
      raw[ANGLE_BITS-1:0] = gen_angle + 12'(2048 + $urandom_range(0, 6) - 3);
    end
    send_sample(raw, t_us, ok);
    ok_out = ok;
  endtask

  initial begin
    logic [TIME_W-1:0] starts[6];
    bit                ok;
    int                taken;
    starts[0] = 48'hFFFF_FFFF_FFFF;
    starts[1] = 48'h0;
    starts[2] = 48'({$urandom, $urandom});
    starts[3] = 48'hFFFF_FFFF_FF00;
    starts[4] = 48'({$urandom, $urandom});
    starts[5] = 48'($urandom);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_sample(16'h0000, 48'd0, 1'b1);
    send_sample(16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_sample(16'h0800, 48'd10, 1'b1);
    send_sample(16'h0800, 48'd10, 1'b1);
    send_sample(16'h0000, 48'd20, 1'b1);
    send_sample(16'hFFFF, 48'd21, 1'b1);
    send_sample(16'h0000, 48'd22, 1'b1);
    send_sample(16'h1800, 48'd23, 1'b1);
    send_sample(16'h0000, 48'd24, 1'b1);
    send_sample(16'h0001, 48'd24, 1'b1);
    send_sample(16'h0000, 48'd24, 1'b1);
    send_sample(16'h0801, 48'd23, 1'b1);
    send_sample(16'hF123, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_sample(16'h0123, 48'd5, 1'b1);
    send_sample(16'h0FFF, 48'h8000_0000_0000, 1'b1);
    send_sample(16'h0000, 48'h8000_0000_0000, 1'b0);
    send_sample(16'h7FFF, 48'h8000_0000_1000, 1'b1);
    send_sample(16'h8000, 48'h8000_0000_1001, 1'b1);
    send_sample(16'h0400, 48'h8000_0001_0000, 1'b1);
    send_sample(16'hAAAA, 48'hAAAA_AAAA_AAAA, 1'b1);
    send_sample(16'h5555, 48'h5555_5555_5555, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      write_start(starts[phase]);
      if (phase == 5) gaps_on = 1'b0;
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        random_sample(ok);
        if (ok) taken++;
      end
    end

    drain();
    $display("Checked %0d results: %0d with zero elapsed time, %0d with a clamped output.",
             sb.n_checked, sb.n_div_zero, sb.n_clamped);
    $display("Start time register written %0d times, including both extremes.", cfg_writes);
    if (sb.errors == 0) begin
      $display("encoder_velocity_accel_estimator verification clean");
    end else begin
      $display("encoder_velocity_accel_estimator verification failed");
    end
    $finish;
  end

endmodule
